FILE: src/pthc_pkg.sv
package pthc_pkg;

  // register indexes, addressed at 8*index
  localparam logic [2:0] REG_TEMP  = 3'd0;
  localparam logic [2:0] REG_PLO   = 3'd1;
  localparam logic [2:0] REG_PHI   = 3'd2;
  localparam logic [2:0] REG_MIX   = 3'd3;
  localparam logic [2:0] REG_HUM   = 3'd4;

  localparam int unsigned DIV_STG   = 64;  // one quotient bit per stage
  localparam int unsigned PRE_STG   = 13;  // stages before the divider
  localparam int unsigned POST_STG  = 5;   // stages after the divider
  localparam int unsigned NUM_STG   = PRE_STG + DIV_STG + POST_STG;

  localparam logic signed [32:0] T_FINE_P_OFS = 33'sd128000;
  localparam logic signed [31:0] T_FINE_H_OFS = 32'sd76800;
  localparam logic [20:0]        P_FULL       = 21'd1048576;
  localparam logic signed [63:0] P_DIV_SCALE  = 64'sd3125;
  localparam logic signed [63:0] P1_OFS       = 64'sh0000_8000_0000_0000;
  localparam logic signed [31:0] H_MAX        = 32'sd419430400;
  localparam logic signed [31:0] H_RND        = 32'sd16384;
  localparam logic signed [31:0] H_Y_OFS      = 32'sd2097152;
  localparam logic signed [31:0] H_V3_OFS     = 32'sd32768;
  localparam logic signed [31:0] H_Y_RND      = 32'sd8192;

  typedef struct packed {
    logic [15:0] tc;
    logic [16:0] hum;
    logic        inval;
    logic        neg;
  } side_t;

endpackage

FILE: src/pth_sensor_compensation.sv
// Channel  | Direction | Ports
// ---------+-----------+--------------------------------------------------
// in       | request   | in_valid/in_ready, in_raw_temperature/pressure/humidity
// out      | result    | out_valid/out_ready, out_temperature_cdeg, out_pressure_pa,
//          |           | out_pressure_invalid, out_humidity_q10
// config   | APB r/w   | psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// Fully pipelined: one request per cycle while the output is taken (13 arithmetic
// stages, a 64-stage restoring divider, 5 stages after it, output register).
// The 64-bit pressure division sets the depth: one quotient bit per stage.
// rst_n (synchronous) clears the stage valid bits and the coefficients.
// When the output register is full and not taken, every stage holds.
module pth_sensor_compensation (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [19:0] in_raw_temperature,
  input  logic [19:0] in_raw_pressure,
  input  logic [15:0] in_raw_humidity,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] out_temperature_cdeg,
  output logic [23:0] out_pressure_pa,
  output logic        out_pressure_invalid,
  output logic [16:0] out_humidity_q10,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  // ---------------- configuration ----------------
  logic [47:0] temp_coeffs_r;
  logic [63:0] plo_r;
  logic [63:0] phi_r;
  logic [47:0] mix_r;
  logic [31:0] hum_coeffs_r;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_coeffs_r <= '0;
      plo_r         <= '0;
      phi_r         <= '0;
      mix_r         <= '0;
      hum_coeffs_r  <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        pthc_pkg::REG_TEMP: temp_coeffs_r <= pwdata[47:0];
        pthc_pkg::REG_PLO:  plo_r         <= pwdata;
        pthc_pkg::REG_PHI:  phi_r         <= pwdata;
        pthc_pkg::REG_MIX:  mix_r         <= pwdata[47:0];
        pthc_pkg::REG_HUM:  hum_coeffs_r  <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      pthc_pkg::REG_TEMP: prdata = {16'd0, temp_coeffs_r};
      pthc_pkg::REG_PLO:  prdata = plo_r;
      pthc_pkg::REG_PHI:  prdata = phi_r;
      pthc_pkg::REG_MIX:  prdata = {16'd0, mix_r};
      pthc_pkg::REG_HUM:  prdata = {32'd0, hum_coeffs_r};
      default:            prdata = '0;
    endcase
  end

  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2;
  logic [7:0]         h1, h3;
  logic signed [11:0] h4, h5;
  logic signed [7:0]  h6;

  assign t1 = temp_coeffs_r[15:0];
  assign t2 = $signed(temp_coeffs_r[31:16]);
  assign t3 = $signed(temp_coeffs_r[47:32]);
  assign p1 = plo_r[15:0];
  assign p2 = $signed(plo_r[31:16]);
  assign p3 = $signed(plo_r[47:32]);
  assign p4 = $signed(plo_r[63:48]);
  assign p5 = $signed(phi_r[15:0]);
  assign p6 = $signed(phi_r[31:16]);
  assign p7 = $signed(phi_r[47:32]);
  assign p8 = $signed(phi_r[63:48]);
  assign p9 = $signed(mix_r[15:0]);
  assign h1 = mix_r[23:16];
  assign h2 = $signed(mix_r[39:24]);
  assign h3 = mix_r[47:40];
  assign h4 = $signed(hum_coeffs_r[11:0]);
  assign h5 = $signed(hum_coeffs_r[23:12]);
  assign h6 = $signed(hum_coeffs_r[31:24]);

  // ---------------- pipeline control ----------------
  logic                         en;
  logic [pthc_pkg::NUM_STG-1:0] vld_r;
  logic                         out_valid_r;

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[pthc_pkg::NUM_STG-2:0], in_valid};
      out_valid_r <= vld_r[pthc_pkg::NUM_STG-1];
    end
  end

  // ---------------- stages 1..13 ----------------
  logic signed [31:0] s1_d1_r, s1_d2_r, s2_m1_r, s2_m2_r, s3_a_r, s3_m3_r, s4_tf_r;
  logic [19:0]        s1_adcp_r, s2_adcp_r, s3_adcp_r, s4_adcp_r, s5_adcp_r;
  logic [19:0]        s6_adcp_r, s7_adcp_r, s8_adcp_r;
  logic [15:0]        s1_adch_r, s2_adch_r, s3_adch_r, s4_adch_r, s5_adch_r;
  logic [15:0]        s5_tc_r, s6_tc_r, s7_tc_r, s8_tc_r, s9_tc_r, s10_tc_r;
  logic signed [32:0] s5_w1_r;
  logic signed [31:0] s5_v_r;
  logic signed [63:0] s6_w1sq_r, s6_w1p5_r, s6_w1p2_r;
  logic signed [31:0] s6_hv5_r, s6_hv6_r, s6_hv3_r, s6_x0_r;
  logic signed [63:0] s7_w2a_r, s7_v1a_r, s7_w1p5_r, s7_w1p2_r;
  logic signed [31:0] s7_x_r, s7_y12_r, s8_x_r, s8_y3_r;
  logic signed [63:0] s8_w2_r, s8_v1_r;
  logic signed [63:0] s9_prod_r, s9_num0_r, s10_dv_r, s10_num_r;
  logic signed [31:0] s9_xy_r, s10_xy_r, s10_a_r, s11_xy_r, s11_aa_r, s12_xy_r, s12_t_r;
  logic [63:0]        s11_ma_r, s11_mb_r, s12_ma_r, s12_mb_r;
  pthc_pkg::side_t    s11_side_r, s12_side_r;

  logic signed [31:0] tc_w, y_w, v3_w;
  logic [15:0]        tc_sat;
  logic [20:0]        pp_w;
  logic [16:0]        hum_w;

  always_comb begin
    tc_w = (s4_tf_r * 32'sd5 + 32'sd128) >>> 8;
    if (tc_w > 32'sd32767)       tc_sat = 16'h7FFF;
    else if (tc_w < -32'sd32768) tc_sat = 16'h8000;
    else                         tc_sat = tc_w[15:0];
    pp_w = pthc_pkg::P_FULL - 21'(s8_adcp_r);
    y_w  = (s8_y3_r + pthc_pkg::H_Y_RND) >>> 14;
    v3_w = s12_xy_r - (s12_t_r >>> 4);
    if (v3_w < 32'sd0)                 hum_w = '0;
    else if (v3_w > pthc_pkg::H_MAX)   hum_w = 17'(pthc_pkg::H_MAX >>> 12);
    else                               hum_w = v3_w[28:12];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // fine temperature
      s1_d1_r   <= 32'(in_raw_temperature >> 3) - (32'(t1) << 1);
      s1_d2_r   <= 32'(in_raw_temperature >> 4) - 32'(t1);
      s1_adcp_r <= in_raw_pressure;
      s1_adch_r <= in_raw_humidity;
      s2_m1_r   <= s1_d1_r * t2;
      s2_m2_r   <= s1_d2_r * s1_d2_r;
      s2_adcp_r <= s1_adcp_r;
      s2_adch_r <= s1_adch_r;
      s3_a_r    <= s2_m1_r >>> 11;
      s3_m3_r   <= (s2_m2_r >>> 12) * t3;
      s3_adcp_r <= s2_adcp_r;
      s3_adch_r <= s2_adch_r;
      s4_tf_r   <= s3_a_r + (s3_m3_r >>> 14);
      s4_adcp_r <= s3_adcp_r;
      s4_adch_r <= s3_adch_r;
      // fork into pressure and humidity
      s5_tc_r   <= tc_sat;
      s5_w1_r   <= 33'(s4_tf_r) - pthc_pkg::T_FINE_P_OFS;
      s5_v_r    <= s4_tf_r - pthc_pkg::T_FINE_H_OFS;
      s5_adcp_r <= s4_adcp_r;
      s5_adch_r <= s4_adch_r;
      s6_w1sq_r <= s5_w1_r * s5_w1_r;
      s6_w1p5_r <= s5_w1_r * p5;
      s6_w1p2_r <= s5_w1_r * p2;
      s6_hv5_r  <= s5_v_r * h5;
      s6_hv6_r  <= s5_v_r * h6;
      s6_hv3_r  <= s5_v_r * $signed({1'b0, h3});
      s6_x0_r   <= $signed((32'(s5_adch_r) << 14) - (32'(h4) << 20)) + pthc_pkg::H_RND;
      s6_adcp_r <= s5_adcp_r;
      s6_tc_r   <= s5_tc_r;
      s7_w2a_r  <= s6_w1sq_r * p6;
      s7_v1a_r  <= s6_w1sq_r * p3;
      s7_w1p5_r <= s6_w1p5_r;
      s7_w1p2_r <= s6_w1p2_r;
      s7_x_r    <= (s6_x0_r - s6_hv5_r) >>> 15;
      s7_y12_r  <= (s6_hv6_r >>> 10) * ((s6_hv3_r >>> 11) + pthc_pkg::H_V3_OFS);
      s7_adcp_r <= s6_adcp_r;
      s7_tc_r   <= s6_tc_r;
      s8_w2_r   <= s7_w2a_r + (s7_w1p5_r <<< 17) + (64'(p4) <<< 35);
      s8_v1_r   <= (s7_v1a_r >>> 8) + (s7_w1p2_r <<< 12);
      s8_y3_r   <= ((s7_y12_r >>> 10) + pthc_pkg::H_Y_OFS) * h2;
      s8_x_r    <= s7_x_r;
      s8_adcp_r <= s7_adcp_r;
      s8_tc_r   <= s7_tc_r;
      s9_prod_r <= (pthc_pkg::P1_OFS + s8_v1_r) * $signed({1'b0, p1});
      s9_num0_r <= $signed(64'(pp_w) << 31) - s8_w2_r;
      s9_xy_r   <= s8_x_r * y_w;
      s9_tc_r   <= s8_tc_r;
      s10_dv_r  <= s9_prod_r >>> 33;
      s10_num_r <= s9_num0_r * pthc_pkg::P_DIV_SCALE;
      s10_a_r   <= s9_xy_r >>> 15;
      s10_xy_r  <= s9_xy_r;
      s10_tc_r  <= s9_tc_r;
      // divider operands as magnitudes
      s11_ma_r         <= s10_num_r[63] ? 64'(-s10_num_r) : 64'(s10_num_r);
      s11_mb_r         <= s10_dv_r[63] ? 64'(-s10_dv_r) : 64'(s10_dv_r);
      s11_side_r.tc    <= s10_tc_r;
      s11_side_r.hum   <= '0;
      s11_side_r.inval <= (s10_dv_r == 64'sd0);
      s11_side_r.neg   <= s10_num_r[63] ^ s10_dv_r[63];
      s11_aa_r         <= s10_a_r * s10_a_r;
      s11_xy_r         <= s10_xy_r;
      s12_t_r          <= (s11_aa_r >>> 7) * $signed({1'b0, h1});
      s12_xy_r         <= s11_xy_r;
      s12_ma_r         <= s11_ma_r;
      s12_mb_r         <= s11_mb_r;
      s12_side_r       <= s11_side_r;
    end
  end

  // ---------------- restoring divider ----------------
  logic [63:0]     dn_r [0:pthc_pkg::DIV_STG];
  logic [63:0]     dm_r [0:pthc_pkg::DIV_STG];
  logic [63:0]     dr_r [0:pthc_pkg::DIV_STG];
  pthc_pkg::side_t ds_r [0:pthc_pkg::DIV_STG];

  always_ff @(posedge clk) begin
    if (en) begin
      dn_r[0]       <= s12_ma_r;
      dm_r[0]       <= s12_mb_r;
      dr_r[0]       <= '0;
      ds_r[0].tc    <= s12_side_r.tc;
      ds_r[0].hum   <= hum_w;
      ds_r[0].inval <= s12_side_r.inval;
      ds_r[0].neg   <= s12_side_r.neg;
    end
  end

  for (genvar k = 0; k < pthc_pkg::DIV_STG; k++) begin : g_div
    logic [63:0] rsh;
    logic        ge;
    assign rsh = {dr_r[k][62:0], dn_r[k][63]};
    assign ge  = (rsh >= dm_r[k]);
    always_ff @(posedge clk) begin
      if (en) begin
        dr_r[k+1] <= ge ? rsh - dm_r[k] : rsh;
        dn_r[k+1] <= {dn_r[k][62:0], ge};
        dm_r[k+1] <= dm_r[k];
        ds_r[k+1] <= ds_r[k];
      end
    end
  end

  // ---------------- after the divider ----------------
  localparam int unsigned DL = pthc_pkg::DIV_STG;

  logic signed [63:0] e1_p_r, e2_p_r, e2_ps_r, e2_a_r, e2_r0_r;
  logic signed [63:0] e3_p_r, e3_r0_r, e4_p_r, e4_q_r, e4_r_r, e5_s_r;
  logic [63:0]        e3_ll_r;
  logic [31:0]        e3_hl_r, e3_lh_r;
  pthc_pkg::side_t    e1_side_r, e2_side_r, e3_side_r, e4_side_r, e5_side_r;
  logic [64:0]        rnd_w;
  logic [23:0]        pres_w;

  always_ff @(posedge clk) begin
    if (en) begin
      e1_p_r    <= ds_r[DL].neg ? -$signed(dn_r[DL]) : $signed(dn_r[DL]);
      e1_side_r <= ds_r[DL];
      e2_ps_r   <= e1_p_r >>> 13;
      e2_a_r    <= (e1_p_r >>> 13) * p9;
      e2_r0_r   <= e1_p_r * p8;
      e2_p_r    <= e1_p_r;
      e2_side_r <= e1_side_r;
      // low 64 bits of a 64x64 product from 32-bit partials
      e3_ll_r   <= 64'(e2_a_r[31:0]) * 64'(e2_ps_r[31:0]);
      e3_hl_r   <= e2_a_r[63:32] * e2_ps_r[31:0];
      e3_lh_r   <= e2_a_r[31:0] * e2_ps_r[63:32];
      e3_r0_r   <= e2_r0_r;
      e3_p_r    <= e2_p_r;
      e3_side_r <= e2_side_r;
      e4_q_r    <= $signed(e3_ll_r + {e3_hl_r + e3_lh_r, 32'd0}) >>> 25;
      e4_r_r    <= e3_r0_r >>> 19;
      e4_p_r    <= e3_p_r;
      e4_side_r <= e3_side_r;
      e5_s_r    <= ((e4_p_r + e4_q_r + e4_r_r) >>> 8) + (64'(p7) <<< 4);
      e5_side_r <= e4_side_r;
    end
  end

  always_comb begin
    rnd_w = {1'b0, e5_s_r} + 65'd128;
    if (e5_side_r.inval || e5_s_r[63]) pres_w = '0;
    else if (rnd_w[64:32] != '0)       pres_w = 24'hFF_FFFF;
    else if (rnd_w[31:8] == 24'hFF_FFFF) pres_w = 24'hFF_FFFF;
    else                               pres_w = rnd_w[31:8];
  end

  logic [15:0] o_tc_r;
  logic [23:0] o_pres_r;
  logic        o_inval_r;
  logic [16:0] o_hum_r;

  always_ff @(posedge clk) begin
    if (en) begin
      o_tc_r    <= e5_side_r.tc;
      o_pres_r  <= pres_w;
      o_inval_r <= e5_side_r.inval;
      o_hum_r   <= e5_side_r.hum;
    end
  end

  assign out_temperature_cdeg = $signed(o_tc_r);
  assign out_pressure_pa      = o_pres_r;
  assign out_pressure_invalid = o_inval_r;
  assign out_humidity_q10     = o_hum_r;

endmodule
